>>> hw/rtl/ecahi_pkg.sv
`timescale 1ns / 1ps
package ecahi_pkg;
  localparam int FUNC_W = 3;
  localparam int SEG_W = 2;
  localparam int RAND_W = 32;
  localparam int IDX_W = 6;
  localparam int INT_W = 17;
  localparam int RULE_W = 8;
  localparam int THR_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int ROW_W = 64;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADVANCE = 3'd0,
    FN_SEED_SINGLE = 3'd1,
    FN_SEED_RANDOM = 3'd2,
    FN_CLEAR = 3'd3,
    FN_SEED_SEGMENT = 3'd4
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_RULE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SEG_W-1:0] seg;
    logic [RAND_W-1:0] bits;
  } cmd_t;
endpackage

>>> hw/rtl/ecahi_if.sv
`timescale 1ns / 1ps
interface ecahi_in_if;
  logic valid;
  logic ready;
  logic [2:0] func;
  logic [1:0] segment_index;
  logic [31:0] random_bits;
  modport source(output valid, func, segment_index, random_bits, input ready);
  modport sink(input valid, func, segment_index, random_bits, output ready);
endinterface

interface ecahi_out_if;
  logic valid;
  logic ready;
  logic [5:0] cell_index;
  logic [16:0] intensity;
  logic newest_state;
  logic last;
  modport source(output valid, cell_index, intensity, newest_state, last, input ready);
  modport sink(input valid, cell_index, intensity, newest_state, last, output ready);
endinterface

>>> hw/rtl/elementary_ca_history_intensity_core.sv
`timescale 1ns / 1ps
// Elementary cellular automaton core with a circular generation history.
// Input channel: one item is one tick (func, segment_index, random_bits).
// Output channel: STEPS*OUTPUTS results per tick, in cell order, with last
// set on the final cell. Each result gives the thresholded column density.
// Configuration: cfg_we with cfg_index 0 (rule) or 1 (threshold), write only,
// written by the user while idle, unchecked; takes effect for the next tick.
// Sequence: the tick is taken from the queue in S_IDLE; when seeding or
// clearing, S_CLEAR zeros the history (only the chosen segment for a
// segment seed); S_SEED writes the seed row; S_GEN runs the generations;
// then per cell S_DIV takes the column sum and, if the threshold is below
// GENERATIONS and the sum above it, runs a restoring divider that produces
// one quotient bit per cycle; S_EMIT then presents the result.
// A two-entry queue lets the front accept up to two ticks while the back
// works. When the receiver stalls, the current result holds and the back
// waits; the queue fills and then in_ready drops.
// After reset a clearing pass zeros every generation of the history
// before the first tick is taken from the queue; rule resets to 30 and
// threshold to 0.
module elementary_ca_history_intensity_core #(
  parameter int STEPS = 16,
  parameter int OUTPUTS = 4,
  parameter int GENERATIONS = 8
) (
  input  logic clk,
  input  logic rst_n,
  ecahi_in_if.sink in_ch,
  ecahi_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [ecahi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecahi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ecahi_pkg::*;

  logic [RULE_W-1:0] rule_r;
  logic [THR_W-1:0] thr_r;
  cmd_t q_data;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= 8'd30;
      thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RULE: rule_r <= cfg_wdata;
        REG_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  ecahi_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  ecahi_back #(.STEPS(STEPS), .OUTPUTS(OUTPUTS), .GENERATIONS(GENERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .rule_number(rule_r), .count_threshold(thr_r), .out_ch(out_ch)
  );
endmodule

>>> hw/rtl/ecahi_front.sv
`timescale 1ns / 1ps
module ecahi_front (
  input  logic clk,
  input  logic rst_n,
  ecahi_in_if.sink in_ch,
  output ecahi_pkg::cmd_t q_data,
  output logic q_valid,
  input  logic q_pop
);
  import ecahi_pkg::*;

  cmd_t buf_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= '{func: in_ch.func, seg: in_ch.segment_index, bits: in_ch.random_bits};
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ch.ready) else $error("ready while full");
`endif
endmodule

>>> hw/rtl/ecahi_back.sv
`timescale 1ns / 1ps
module ecahi_back #(
  parameter int STEPS = 16,
  parameter int OUTPUTS = 4,
  parameter int GENERATIONS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  ecahi_pkg::cmd_t q_data,
  input  logic q_valid,
  output logic q_pop,
  input  logic [7:0] rule_number,
  input  logic [2:0] count_threshold,
  ecahi_out_if.source out_ch
);
  import ecahi_pkg::*;

  localparam int CELLS = STEPS * OUTPUTS;
  localparam int PW = (GENERATIONS > 1) ? $clog2(GENERATIONS) : 1;
  localparam int CW = $clog2(GENERATIONS + 1);
  localparam int XW = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLEAR = 6'b000010,
    S_SEED = 6'b000100,
    S_GEN = 6'b001000,
    S_DIV = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r;
  logic [CELLS-1:0] rows_r [GENERATIONS];
  logic [PW-1:0] ptr_r;
  logic [PW-1:0] g_r;
  logic [4:0] runs_r;
  cmd_t cmd_r;
  logic [CELLS-1:0] mask_r;
  logic [XW-1:0] x_r;
  logic [CW-1:0] sum_r;
  logic [16:0] q_r;
  logic [4:0] dbit_r;
  logic [CW+17:0] rem_r;
  logic init_r;
  logic [CELLS-1:0] src, dst, seedrow;
  logic [PW-1:0] ptr_dn;
  logic [CW-1:0] colsum;
  logic [CW-1:0] d;
  logic thr_ok;
  logic [CW+17:0] trial;

  assign src = rows_r[ptr_r];
  assign ptr_dn = (ptr_r == '0) ? PW'(GENERATIONS - 1) : ptr_r - 1'b1;

  always_comb begin
    for (int x = 0; x < CELLS; x++) begin
      dst[x] = rule_number[{src[(x + CELLS - 1) % CELLS], src[x], src[(x + 1) % CELLS]}];
      seedrow[x] = ((x % 2) == 0 && (x / 2) < 32) ? cmd_r.bits[(x / 2) % 32] : 1'b0;
    end
  end

  always_comb begin
    colsum = '0;
    for (int g = 0; g < GENERATIONS; g++) colsum = colsum + CW'(rows_r[g][x_r]);
  end

  assign thr_ok = {2'b0, count_threshold} < 5'(GENERATIONS);
  assign d = CW'(GENERATIONS) - CW'(count_threshold);
  assign trial = rem_r - ((CW+18)'(d) << dbit_r);

  assign out_ch.valid = (state_r == S_EMIT);
  assign out_ch.cell_index = 6'(x_r);
  assign out_ch.intensity = (q_r > ONE_Q16) ? ONE_Q16 : q_r;
  assign out_ch.newest_state = src[x_r];
  assign out_ch.last = (x_r == XW'(CELLS - 1));
  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r <= '0;
      g_r <= '0;
      x_r <= '0;
      init_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          cmd_r <= q_data;
          runs_r <= '0;
          x_r <= '0;
          g_r <= '0;
          mask_r <= '1;
          state_r <= S_DIV;
          sum_r <= colsum;
          unique case (q_data.func)
            FN_ADVANCE: begin runs_r <= 5'd1; state_r <= S_GEN; end
            FN_SEED_SINGLE: state_r <= S_CLEAR;
            FN_SEED_RANDOM: state_r <= S_CLEAR;
            FN_CLEAR: state_r <= S_CLEAR;
            FN_SEED_SEGMENT: begin
              for (int x = 0; x < CELLS; x++)
                mask_r[x] <= ((x / STEPS) == int'(q_data.seg));
              state_r <= (int'(q_data.seg) < OUTPUTS) ? S_CLEAR : S_DIV;
            end
            default: state_r <= S_DIV;
          endcase
          rem_r <= '0;
        end
        S_CLEAR: begin
          rows_r[g_r] <= rows_r[g_r] & ~mask_r;
          g_r <= g_r + 1'b1;
          if (g_r == PW'(GENERATIONS - 1)) begin
            g_r <= '0;
            init_r <= 1'b0;
            if (init_r) state_r <= S_IDLE;
            else state_r <= (cmd_r.func == FN_CLEAR) ? S_DIV : S_SEED;
          end
        end
        S_SEED: begin
          if (cmd_r.func == FN_SEED_SINGLE) begin
            rows_r[ptr_r] <= src | CELLS'(1);
            runs_r <= {2'b0, count_threshold};
          end else begin
            rows_r[ptr_r] <= (src & ~mask_r) | (seedrow & mask_r)
              | (CELLS'(1) << (cmd_r.func == FN_SEED_SEGMENT ? int'(cmd_r.seg) * STEPS : 0));
            runs_r <= (cmd_r.func == FN_SEED_RANDOM) ? 5'(GENERATIONS) : 5'd0;
          end
          state_r <= S_GEN;
        end
        S_GEN: begin
          if (runs_r == 5'd0) begin
            state_r <= S_DIV;
          end else begin
            rows_r[ptr_dn] <= dst;
            ptr_r <= ptr_dn;
            runs_r <= runs_r - 1'b1;
          end
          sum_r <= '0;
          dbit_r <= 5'd16;
          rem_r <= '0;
        end
        S_DIV: begin
          if (rem_r == '0 && dbit_r == 5'd16 && q_r != 17'h1ffff) begin
            sum_r <= colsum;
            rem_r <= ((CW+18)'(colsum - CW'(count_threshold)) << 16) + (CW+18)'(d >> 1);
            q_r <= 17'h1ffff;
          end else if (!(thr_ok && sum_r > CW'(count_threshold))) begin
            q_r <= '0;
            state_r <= S_EMIT;
          end else begin
            if (!trial[CW+17]) begin
              rem_r <= trial;
              q_r[dbit_r] <= 1'b1;
            end else q_r[dbit_r] <= 1'b0;
            if (dbit_r == 5'd0) state_r <= S_EMIT;
            else dbit_r <= dbit_r - 1'b1;
          end
        end
        S_EMIT: if (out_ch.ready) begin
          dbit_r <= 5'd16;
          rem_r <= '0;
          q_r <= '0;
          if (out_ch.last) state_r <= S_IDLE;
          else begin
            x_r <= x_r + 1'b1;
            state_r <= S_DIV;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE && q_valid) begin
        dbit_r <= 5'd16;
        q_r <= '0;
      end
      if (state_r == S_CLEAR && cmd_r.func == FN_ADVANCE) mask_r <= '1;
    end
    if (!rst_n) mask_r <= '1;
    if (!rst_n) cmd_r.func <= FN_CLEAR;
  end

`ifndef ASSERT_OFF
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (int'(x_r) < CELLS)) else $error("cell index out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(x_r)))
    else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_ch.valid) else $error("pop during emit");
`endif
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ecahi_pkg::*;

  localparam int CELLS = 64;
  localparam int DEPTH = 8;
  localparam int LIMIT_CYCLES = 5000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 4000;
  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic [INT_W-1:0] intensity;
    logic newest_state;
    logic last;
  } cell_result_t;

  class ca_scoreboard;
    logic [ROW_W-1:0] rows[DEPTH];
    int unsigned newest;
    logic [RULE_W-1:0] rule;
    logic [THR_W-1:0] thr;
    cell_result_t pending_cells[$];
    int unsigned errors;

    function new();
      foreach (rows[g]) rows[g] = '0;
      newest = 0;
      rule = 8'd30;
      thr = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_RULE) rule = data[RULE_W-1:0];
      else if (idx == REG_THRESHOLD) thr = data[THR_W-1:0];
    endfunction

    function void step_generation();
      logic [ROW_W-1:0] src;
      logic [ROW_W-1:0] dst;
      logic [2:0] pat;
      src = rows[newest];
      dst = '0;
      for (int x = 0; x < CELLS; x++) begin
        pat = {src[(x + CELLS - 1) % CELLS], src[x], src[(x + 1) % CELLS]};
        dst[x] = rule[pat];
      end
      newest = (newest == 0) ? DEPTH - 1 : newest - 1;
      rows[newest] = dst;
    endfunction

    function void seed_cells(int lo, int hi, logic [RAND_W-1:0] bits);
      for (int g = 0; g < DEPTH; g++)
        for (int x = lo; x < hi; x++) rows[g][x] = 1'b0;
      for (int x = lo; x < hi; x++)
        if (x % 2 == 0) rows[newest][x] = (x / 2 < RAND_W) ? bits[x / 2] : 1'b0;
      rows[newest][lo] = 1'b1;
    endfunction

    function void note_tick(logic [FUNC_W-1:0] fn, logic [SEG_W-1:0] seg,
                            logic [RAND_W-1:0] bits);
      cell_result_t r;
      int unsigned count;
      int unsigned d;
      int unsigned q;
      case (fn)
        FN_ADVANCE: step_generation();
        FN_SEED_SINGLE: begin
          foreach (rows[g]) rows[g] = '0;
          rows[newest][0] = 1'b1;
          for (int i = 0; i < thr; i++) step_generation();
        end
        FN_SEED_RANDOM: begin
          seed_cells(0, CELLS, bits);
          for (int i = 0; i < DEPTH; i++) step_generation();
        end
        FN_CLEAR: foreach (rows[g]) rows[g] = '0;
        FN_SEED_SEGMENT: if (seg < 4) seed_cells(seg * 16, seg * 16 + 16, bits);
        default: ;
      endcase
      for (int x = 0; x < CELLS; x++) begin
        count = 0;
        for (int g = 0; g < DEPTH; g++) count += rows[g][x];
        q = 0;
        if (thr < DEPTH && count > thr) begin
          d = DEPTH - thr;
          q = ((count - thr) * 65536 + d / 2) / d;
          if (q > 65536) q = 65536;
        end
        r.cell_index = IDX_W'(x);
        r.intensity = INT_W'(q);
        r.newest_state = rows[newest][x];
        r.last = (x == CELLS - 1);
        pending_cells.push_back(r);
      end
    endfunction

    function void check(cell_result_t got);
      cell_result_t exp;
      if (pending_cells.size() == 0) begin
        $error("unexpected result cell_index=%0d", got.cell_index);
        errors++;
        return;
      end
      exp = pending_cells.pop_front();
      if (got.cell_index !== exp.cell_index) begin
        $error("cell_index expected %0d actual %0d", exp.cell_index, got.cell_index);
        errors++;
      end
      if (got.intensity !== exp.intensity) begin
        $error("intensity expected %0d actual %0d", exp.intensity, got.intensity);
        errors++;
      end
      if (got.newest_state !== exp.newest_state) begin
        $error("newest_state expected %0d actual %0d", exp.newest_state, got.newest_state);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last expected %0d actual %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  ecahi_in_if in_ch();
  ecahi_out_if out_ch();
  ca_scoreboard ca_sb;
  bit quiet;
  int unsigned cells_seen;

  elementary_ca_history_intensity_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall_left;
    bit long_hold_done;
    cell_result_t got;
    stall_left = 0;
    long_hold_done = 0;
    cells_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.cell_index = out_ch.cell_index;
        got.intensity = out_ch.intensity;
        got.newest_state = out_ch.newest_state;
        got.last = out_ch.last;
        ca_sb.check(got);
        cells_seen++;
      end
      if (!long_hold_done && cells_seen >= 3000) begin
        long_hold_done = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(logic [FUNC_W-1:0] fn, logic [SEG_W-1:0] seg,
                           logic [RAND_W-1:0] bits);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.segment_index <= seg;
    in_ch.random_bits <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ca_sb.note_tick(fn, seg, bits);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ca_sb.pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    ca_sb.write_reg(idx, data);
  endtask

  task automatic random_tick();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) send_tick(FN_ADVANCE, SEG_W'($urandom), $urandom);
    else if (pick < 68) send_tick(FN_SEED_SINGLE, SEG_W'($urandom), $urandom);
    else if (pick < 76) send_tick(FN_SEED_RANDOM, SEG_W'($urandom), $urandom);
    else if (pick < 80) send_tick(FN_CLEAR, SEG_W'($urandom), $urandom);
    else if (pick < 94) send_tick(FN_SEED_SEGMENT, SEG_W'($urandom), $urandom);
    else send_tick(FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST)),
                   SEG_W'($urandom), $urandom);
  endtask

  initial begin
    logic [RULE_W-1:0] rules[6];
    logic [THR_W-1:0] thrs[6];
    ca_sb = new();
    quiet = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= '0;
    in_ch.segment_index <= '0;
    in_ch.random_bits <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(FN_SEED_SINGLE, 2'd0, 32'h0);
    repeat (3) send_tick(FN_ADVANCE, 2'd0, 32'h0);
    send_tick(FN_SEED_RANDOM, 2'd3, 32'hFFFF_FFFF);
    send_tick(FN_SEED_RANDOM, 2'd0, 32'h0);
    send_tick(FN_CLEAR, 2'd0, 32'h0);
    for (int s = 0; s < 4; s++) send_tick(FN_SEED_SEGMENT, SEG_W'(s), 32'hA5C3_0FF1);
    send_tick(FN_SEED_SEGMENT, 2'd3, 32'hFFFF_FFFF);
    for (int f = FN_UNUSED_FIRST; f <= FN_UNUSED_LAST; f++)
      send_tick(FUNC_W'(f), 2'd1, 32'h1);
    send_tick(FN_ADVANCE, 2'd2, 32'h0);
    wait_idle();
    write_reg(REG_THRESHOLD, 8'd7);
    write_reg(REG_RULE, 8'd255);
    send_tick(FN_SEED_SINGLE, 2'd0, 32'h0);
    send_tick(FN_ADVANCE, 2'd0, 32'h0);
    wait_idle();
    write_reg(REG_RULE, 8'd0);
    send_tick(FN_SEED_RANDOM, 2'd1, 32'h5555_AAAA);
    send_tick(FN_ADVANCE, 2'd0, 32'h0);
    wait_idle();

    rules = '{8'd30, 8'd110, 8'd0, 8'd255, 8'd90, 8'd150};
    thrs = '{3'd0, 3'd3, 3'd7, 3'd1, 3'd5, 3'd2};
    rules[5] = RULE_W'($urandom);
    thrs[5] = THR_W'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_RULE, CFG_DATA_W'(rules[p]));
      write_reg(REG_THRESHOLD, CFG_DATA_W'(thrs[p]));
      for (int i = 0; i < 60; i++) begin
        if (p == 5 && i >= 20) quiet = 1;
        random_tick();
      end
      wait_idle();
    end

    if (ca_sb.errors == 0 && ca_sb.pending_cells.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
